### rtl/psu_pkg.sv
// Shared types, constants and arithmetic helpers for the PNG scanline unfilter.
package psu_pkg;

    localparam int MAX_LINE_BYTES = 16384;
    localparam int X_W            = $clog2(MAX_LINE_BYTES);
    localparam int COL_W          = X_W + 1;
    localparam int LB_W           = 15;
    localparam int BPP_W          = 3;
    localparam int CFG_IDX_W      = 1;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = $clog2(Q_DEPTH);
    localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 1'b1;

    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;
    localparam logic [LB_W-1:0]  LB_RESET  = 15'd1;

    typedef enum logic [1:0] {
        KIND_ROW  = 2'd0,   // filter byte: start of a row
        KIND_DATA = 2'd1,   // filtered data byte
        KIND_ERR  = 2'd2    // filter code out of range
    } kind_t;

    typedef struct packed {
        kind_t          kind;
        logic [7:0]     raw;
        logic [2:0]     filt;
        logic           first_row;
        logic           last;
        logic [X_W-1:0] x;
    } item_t;

    function automatic logic [7:0] pick_byte(input logic [31:0] h, input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = h[7:0];
            2'd1:    r = h[15:8];
            2'd2:    r = h[23:16];
            default: r = h[31:24];
        endcase
        return r;
    endfunction

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [7:0] pa;
        logic [7:0] pb;
        logic [8:0] ab;
        logic [8:0] cc;
        logic [8:0] pc;
        logic [7:0] r;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        ab = {1'b0, a} + {1'b0, b};
        cc = {c, 1'b0};
        pc = (ab > cc) ? ab - cc : cc - ab;
        if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc)
            r = a;
        else if ({1'b0, pb} <= pc)
            r = b;
        else
            r = c;
        return r;
    endfunction

endpackage

### rtl/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: config registers, front, queue, back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | byte_valid / byte_ready| raw_byte[7:0], frame_start
//  output   | pix_valid / pix_ready  | pixel_byte[7:0], row_last, bad_filter
//  config   | cfg_valid / cfg_ready  | cfg_index[0], cfg_data[14:0]
//
// One word per cycle sustained while pix_ready holds. A data word is queued
// on acceptance; the line store is read for it on pop, and the result is
// computed into the output register that drives pix_valid. The line store
// has one write and one read port.
// byte_ready drops only when the two-entry queue is full, i.e. when the
// output side has stalled long enough to back up the back end.
// Reset clears control state only; the line store is never cleared since
// the first row of every frame ignores it.
// Good filter words, and words dropped after a bad one, give no output.
module png_scanline_unfilter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  raw_byte,
    input  logic        frame_start,
    output logic        pix_valid,
    input  logic        pix_ready,
    output logic [7:0]  pixel_byte,
    output logic        row_last,
    output logic        bad_filter,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [psu_pkg::LB_W-1:0]      cfg_data
);
    import psu_pkg::*;

    logic [LB_W-1:0]  line_bytes_reg, line_bytes_next;
    logic [BPP_W-1:0] bpp_reg, bpp_next;

    logic [COL_W-1:0] len_eff;
    logic [1:0]       bpp_idx;
    logic             accept;
    logic             push;
    item_t            push_item;
    logic             q_full;
    logic             head_valid;
    item_t            head_item;
    logic             pop;

    assign cfg_ready  = 1'b1;
    assign byte_ready = !q_full;
    assign accept     = byte_valid && byte_ready;

    // config write; only legal while idle
    always_comb
    begin
        line_bytes_next = line_bytes_reg;
        bpp_next        = bpp_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LINE_BYTES: line_bytes_next = cfg_data;
                default:        bpp_next        = cfg_data[BPP_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg <= LB_RESET;
            bpp_reg        <= BPP_RESET;
        end
        else
        begin
            line_bytes_reg <= line_bytes_next;
            bpp_reg        <= bpp_next;
        end
    end

    // clamp: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (line_bytes_reg == '0)
            len_eff = COL_W'(1);
        else if (COL_W'(line_bytes_reg) > COL_W'(MAX_LINE_BYTES))
            len_eff = COL_W'(MAX_LINE_BYTES);
        else
            len_eff = COL_W'(line_bytes_reg);

        if (bpp_reg == '0)
            bpp_idx = 2'd0;
        else if (bpp_reg > BPP_MAX)
            bpp_idx = 2'd3;
        else
            bpp_idx = 2'(bpp_reg - 3'd1);
    end

    psu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .raw_byte    (raw_byte),
        .frame_start (frame_start),
        .len_eff     (len_eff),
        .push        (push),
        .push_item   (push_item)
    );

    psu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    psu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .bpp_idx    (bpp_idx),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pixel_byte (pixel_byte),
        .row_last   (row_last),
        .bad_filter (bad_filter)
    );

endmodule

### rtl/psu_front.sv
// Front end: tracks row position and filter code, classifies incoming words.
module psu_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               raw_byte,
    input  logic                     frame_start,
    input  logic [psu_pkg::COL_W-1:0] len_eff,
    output logic                     push,
    output psu_pkg::item_t           push_item
);
    import psu_pkg::*;

    logic [COL_W-1:0] column_reg, column_next;
    logic             halted_reg, halted_next;
    logic             first_row_reg, first_row_next;
    logic [2:0]       filt_reg, filt_next;

    logic [COL_W-1:0] col_cur;
    logic             first_cur;
    logic [COL_W-1:0] col_m1;
    logic             last;

    always_comb
    begin
        col_cur   = frame_start ? '0 : column_reg;
        first_cur = frame_start ? 1'b1 : first_row_reg;
        col_m1    = col_cur - COL_W'(1);
        last      = (col_cur >= len_eff);

        column_next    = column_reg;
        halted_next    = halted_reg;
        first_row_next = first_row_reg;
        filt_next      = filt_reg;
        push           = 1'b0;

        push_item.kind      = KIND_DATA;
        push_item.raw       = raw_byte;
        push_item.filt      = filt_reg;
        push_item.first_row = first_cur;
        push_item.last      = last;
        push_item.x         = col_m1[X_W-1:0];

        if (accept && (frame_start || !halted_reg))
        begin
            push           = 1'b1;
            halted_next    = 1'b0;
            first_row_next = first_cur;
            column_next    = col_cur;
            if (col_cur == '0)
            begin
                if (raw_byte > {5'd0, FILT_PAETH})
                begin
                    push_item.kind = KIND_ERR;
                    halted_next    = 1'b1;
                end
                else
                begin
                    push_item.kind = KIND_ROW;
                    filt_next      = raw_byte[2:0];
                    column_next    = COL_W'(1);
                end
            end
            else if (last)
            begin
                column_next    = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                column_next = col_cur + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            halted_reg    <= 1'b0;
            first_row_reg <= 1'b1;
            filt_reg      <= FILT_NONE;
        end
        else
        begin
            column_reg    <= column_next;
            halted_reg    <= halted_next;
            first_row_reg <= first_row_next;
            filt_reg      <= filt_next;
        end
    end

endmodule

### rtl/psu_queue.sv
// Short FIFO of classified items between front end and back end.
module psu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psu_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output psu_pkg::item_t head_item
);
    import psu_pkg::*;

    item_t              slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_pop;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (!push && do_pop)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/psu_back.sv
// Back end: line store, neighbor history, reconstruction and output register.
module psu_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  psu_pkg::item_t head_item,
    output logic           pop,
    input  logic [1:0]     bpp_idx,
    output logic           pix_valid,
    input  logic           pix_ready,
    output logic [7:0]     pixel_byte,
    output logic           row_last,
    output logic           bad_filter
);
    import psu_pkg::*;

    logic [7:0] line_mem [MAX_LINE_BYTES];

    logic        s1_valid_reg, s1_valid_next;
    item_t       s1_item_reg;
    logic        s1_new_reg;
    logic [7:0]  rd_data_reg;
    logic [7:0]  b_hold_reg;
    logic [31:0] left_reg, left_next;
    logic [31:0] upper_reg, upper_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_pix_reg;
    logic        out_last_reg;
    logic        out_bad_reg;

    logic        out_free;
    logic        fire;
    logic        wr_en;
    logic [7:0]  b_cur;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [8:0]  ab_sum;
    logic [7:0]  pred;
    logic [7:0]  v;

    assign out_free = !out_valid_reg || pix_ready;
    assign fire     = s1_valid_reg && (s1_item_reg.kind == KIND_ROW || out_free);
    assign pop      = head_valid && (!s1_valid_reg || fire);
    assign wr_en    = fire && s1_item_reg.kind == KIND_DATA;

    // rows are always separated by a filter word, so a read never meets
    // a same-address write in the same cycle
    assign b_cur = s1_new_reg ? rd_data_reg : b_hold_reg;

    always_comb
    begin
        a      = pick_byte(left_reg, bpp_idx);
        c      = pick_byte(upper_reg, bpp_idx);
        b      = s1_item_reg.first_row ? 8'd0 : b_cur;
        ab_sum = {1'b0, a} + {1'b0, b};
        unique case (s1_item_reg.filt)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = ab_sum[8:1];
            FILT_PAETH: pred = paeth(a, b, c);
            default:    pred = 8'd0;
        endcase
        v = s1_item_reg.raw + pred;
    end

    always_comb
    begin
        s1_valid_next  = pop ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        left_next      = left_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg && !pix_ready;
        if (fire)
        begin
            unique case (s1_item_reg.kind)
                KIND_ROW:
                begin
                    left_next  = '0;
                    upper_next = '0;
                end
                KIND_DATA:
                begin
                    left_next      = {left_reg[23:0], v};
                    upper_next     = {upper_reg[23:0], b};
                    out_valid_next = 1'b1;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_item_reg.x] <= v;
        rd_data_reg <= line_mem[head_item.x];
    end

    always_ff @(posedge clk)
    begin
        b_hold_reg <= b_cur;
        if (pop)
            s1_item_reg <= head_item;
        if (fire && s1_item_reg.kind != KIND_ROW)
        begin
            out_pix_reg  <= (s1_item_reg.kind == KIND_DATA) ? v : 8'd0;
            out_last_reg <= (s1_item_reg.kind == KIND_DATA) && s1_item_reg.last;
            out_bad_reg  <= (s1_item_reg.kind == KIND_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_new_reg    <= 1'b0;
            left_reg      <= '0;
            upper_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_new_reg    <= pop;
            left_reg      <= left_next;
            upper_reg     <= upper_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign pix_valid  = out_valid_reg;
    assign pixel_byte = out_pix_reg;
    assign row_last   = out_last_reg;
    assign bad_filter = out_bad_reg;

endmodule
